// ===== rtl/shader_alu_helper_unit_macros.svh =====
// shader_alu_helper_unit_macros.svh: assertion macros for the helper alu
// depends on: nothing; expects clk_i and rst_ni in the including module
`ifndef SHADER_ALU_HELPER_UNIT_MACROS_SVH
`define SHADER_ALU_HELPER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sau_pkg.sv =====
// sau_pkg: operation codes, result struct and float constants
// depends on: nothing
package sau_pkg;

  typedef enum logic [2:0] {
    OP_SHL   = 3'd0,
    OP_SHR   = 3'd1,
    OP_ADDC  = 3'd2,
    OP_F2H   = 3'd3,
    OP_CLASS = 3'd4,
    OP_FMIN  = 3'd5,
    OP_FMAX  = 3'd6
  } op_e;

  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
    logic        flag;
  } result_t;

  // float16 encodings
  localparam logic [15:0] H_MAX_FINITE = 16'h7bff;
  localparam logic [15:0] H_INF        = 16'h7c00;
  localparam logic [15:0] H_QUIET      = 16'h0200;

  // float32 exponent thresholds for the half conversion
  localparam logic [7:0] EXP_ALL_ONES = 8'd255;
  localparam logic [7:0] EXP_SAT      = 8'd143;
  localparam logic [7:0] EXP_FLUSH    = 8'd103;
  localparam logic [7:0] EXP_SUB_TOP  = 8'd112;
  localparam logic [7:0] SUB_BIAS     = 8'd126;

  localparam logic [31:0] F_EXP_MASK  = 32'h7f800000;
  localparam logic [31:0] F_MANT_MASK = 32'h007fffff;
  localparam logic [31:0] F_QUIET     = 32'h00400000;

  // class mask bit positions
  localparam int unsigned CL_SNAN = 0;
  localparam int unsigned CL_QNAN = 1;
  localparam int unsigned CL_NINF = 2;
  localparam int unsigned CL_NNRM = 3;
  localparam int unsigned CL_NDEN = 4;
  localparam int unsigned CL_NZER = 5;
  localparam int unsigned CL_PZER = 6;
  localparam int unsigned CL_PDEN = 7;
  localparam int unsigned CL_PNRM = 8;
  localparam int unsigned CL_PINF = 9;

endpackage

// ===== rtl/sau_datapath.sv =====
// sau_datapath: combinational logic for all seven helper operations
// depends on: sau_pkg
module sau_datapath (
  input  logic [2:0]       operation_i,
  input  logic [31:0]      operand_a_i,
  input  logic [31:0]      operand_b_i,
  input  logic [5:0]       shift_amount_i,
  input  logic             carry_in_i,
  input  logic [9:0]       class_mask_i,
  output sau_pkg::result_t result_o
);

  logic [63:0] shl_res, shr_res;
  logic [32:0] sum;

  // f32 to f16
  logic        a_sign;
  logic [7:0]  a_exp;
  logic [22:0] a_mant;
  logic [7:0]  sub_diff, nrm_diff;
  logic [23:0] sub_shifted;
  logic [15:0] half;

  // class test
  logic [3:0]  cl_idx;
  logic        a_exp_ones, a_exp_zero, a_mant_zero;

  // min/max
  logic        a_nan, b_nan, a_snan, b_snan, zero_pair, a_lt;
  logic [31:0] key_a, key_b, fmin_res, fmax_res;

  assign shl_res = {operand_b_i, operand_a_i} << shift_amount_i;
  assign shr_res = {operand_b_i, operand_a_i} >> shift_amount_i;
  assign sum     = {1'b0, operand_a_i} + {1'b0, operand_b_i} + {32'd0, carry_in_i};

  assign a_sign      = operand_a_i[31];
  assign a_exp       = operand_a_i[30:23];
  assign a_mant      = operand_a_i[22:0];
  assign sub_diff    = sau_pkg::SUB_BIAS - a_exp;
  assign nrm_diff    = a_exp - sau_pkg::EXP_SUB_TOP;
  assign sub_shifted = {1'b1, a_mant} >> sub_diff[4:0];

  always_comb begin
    if (a_exp == sau_pkg::EXP_ALL_ONES) begin
      if (a_mant == 23'd0) begin
        half = {a_sign, sau_pkg::H_INF[14:0]};
      end else begin
        half = {a_sign, sau_pkg::H_INF[14:0]} | {6'd0, a_mant[22:13]} | sau_pkg::H_QUIET;
      end
    end else if (a_exp >= sau_pkg::EXP_SAT) begin
      half = {a_sign, sau_pkg::H_MAX_FINITE[14:0]};
    end else if (a_exp < sau_pkg::EXP_FLUSH) begin
      half = {a_sign, 15'd0};
    end else if (a_exp <= sau_pkg::EXP_SUB_TOP) begin
      half = {a_sign, 5'd0, sub_shifted[9:0]};
    end else begin
      half = {a_sign, nrm_diff[4:0], a_mant[22:13]};
    end
  end

  assign a_exp_ones  = (a_exp == 8'hff);
  assign a_exp_zero  = (a_exp == 8'h00);
  assign a_mant_zero = (a_mant == 23'd0);

  always_comb begin
    if (a_exp_ones && !a_mant_zero) begin
      cl_idx = a_mant[22] ? 4'(sau_pkg::CL_QNAN) : 4'(sau_pkg::CL_SNAN);
    end else if (a_exp_ones) begin
      cl_idx = a_sign ? 4'(sau_pkg::CL_NINF) : 4'(sau_pkg::CL_PINF);
    end else if (!a_exp_zero) begin
      cl_idx = a_sign ? 4'(sau_pkg::CL_NNRM) : 4'(sau_pkg::CL_PNRM);
    end else if (!a_mant_zero) begin
      cl_idx = a_sign ? 4'(sau_pkg::CL_NDEN) : 4'(sau_pkg::CL_PDEN);
    end else begin
      cl_idx = a_sign ? 4'(sau_pkg::CL_NZER) : 4'(sau_pkg::CL_PZER);
    end
  end

  assign a_nan  = ((operand_a_i & sau_pkg::F_EXP_MASK) == sau_pkg::F_EXP_MASK)
               && ((operand_a_i & sau_pkg::F_MANT_MASK) != 32'd0);
  assign b_nan  = ((operand_b_i & sau_pkg::F_EXP_MASK) == sau_pkg::F_EXP_MASK)
               && ((operand_b_i & sau_pkg::F_MANT_MASK) != 32'd0);
  assign a_snan = a_nan && ((operand_a_i & sau_pkg::F_QUIET) == 32'd0);
  assign b_snan = b_nan && ((operand_b_i & sau_pkg::F_QUIET) == 32'd0);
  assign zero_pair = (operand_a_i[30:0] == 31'd0) && (operand_b_i[30:0] == 31'd0);

  // monotonic unsigned key of the float ordering
  assign key_a = operand_a_i[31] ? ~operand_a_i : {1'b1, operand_a_i[30:0]};
  assign key_b = operand_b_i[31] ? ~operand_b_i : {1'b1, operand_b_i[30:0]};
  assign a_lt  = key_a < key_b;

  always_comb begin
    if (a_snan) begin
      fmin_res = operand_a_i | sau_pkg::F_QUIET;
      fmax_res = operand_a_i | sau_pkg::F_QUIET;
    end else if (b_snan) begin
      fmin_res = operand_b_i | sau_pkg::F_QUIET;
      fmax_res = operand_b_i | sau_pkg::F_QUIET;
    end else if (a_nan) begin
      fmin_res = operand_b_i;
      fmax_res = operand_b_i;
    end else if (b_nan) begin
      fmin_res = operand_a_i;
      fmax_res = operand_a_i;
    end else if (zero_pair) begin
      fmin_res = operand_a_i | operand_b_i;
      fmax_res = operand_a_i & operand_b_i;
    end else begin
      fmin_res = a_lt ? operand_a_i : operand_b_i;
      fmax_res = a_lt ? operand_b_i : operand_a_i;
    end
  end

  always_comb begin
    result_o = '0;
    case (sau_pkg::op_e'(operation_i))
      sau_pkg::OP_SHL: begin
        result_o.lo = shl_res[31:0];
        result_o.hi = shl_res[63:32];
      end
      sau_pkg::OP_SHR: begin
        result_o.lo = shr_res[31:0];
        result_o.hi = shr_res[63:32];
      end
      sau_pkg::OP_ADDC: begin
        result_o.lo   = sum[31:0];
        result_o.flag = sum[32];
      end
      sau_pkg::OP_F2H: begin
        result_o.lo = {16'd0, half};
      end
      sau_pkg::OP_CLASS: begin
        result_o.flag = class_mask_i[cl_idx];
      end
      sau_pkg::OP_FMIN: begin
        result_o.lo = fmin_res;
      end
      sau_pkg::OP_FMAX: begin
        result_o.lo = fmax_res;
      end
      default: begin
        result_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/shader_alu_helper_unit.sv =====
// shader_alu_helper_unit: top level, input register, datapath and result register
// depends on: sau_pkg, sau_datapath, shader_alu_helper_unit_macros.svh
//
// usage:
//   request channel: in_valid_i / in_stall_o with operation and operands; a
//   request is taken at a clock edge with in_valid_i high and in_stall_o low
//   result channel: out_valid_o / out_stall_i with result_low, result_high and
//   flag; a result is taken at an edge with out_valid_o high and out_stall_i low
//   path: a request passes the input register, then the result register,
//   before out_valid_o rises with its result; the datapath between them is
//   one shallow pass
//   throughput: one request per cycle while out_stall_i is low, two-entry pipeline
//   operation 7 is unused and returns all zeros
//   reset: both valid bits clear, the unit is empty and ready at once
//   receiver stall: the result register holds; one more request can still
//   enter the input register, after which in_stall_o rises until the result
//   is taken
`include "shader_alu_helper_unit_macros.svh"

module shader_alu_helper_unit (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic [5:0]  shift_amount_i,
  input  logic        carry_in_i,
  input  logic [9:0]  class_mask_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_low_o,
  output logic [31:0] result_high_o,
  output logic        flag_o
);

  // input register stage
  logic        s1_valid_q, s1_valid_d;
  logic [2:0]  op_q;
  logic [31:0] a_q, b_q;
  logic [5:0]  amt_q;
  logic        cin_q;
  logic [9:0]  mask_q;

  // result register stage
  logic             out_valid_q, out_valid_d;
  sau_pkg::result_t res_q;
  sau_pkg::result_t dp_res;

  logic advance;   // result register may load this cycle
  logic take_in;   // request accepted this cycle

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign take_in    = in_valid_i && !in_stall_o;

  // stage 1 empties into the result register whenever it advances
  assign s1_valid_d  = take_in || (s1_valid_q && !advance);
  assign out_valid_d = advance ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      op_q   <= operation_i;
      a_q    <= operand_a_i;
      b_q    <= operand_b_i;
      amt_q  <= shift_amount_i;
      cin_q  <= carry_in_i;
      mask_q <= class_mask_i;
    end
    if (advance && s1_valid_q) begin
      res_q <= dp_res;
    end
  end

  sau_datapath u_datapath (
    .operation_i    (op_q),
    .operand_a_i    (a_q),
    .operand_b_i    (b_q),
    .shift_amount_i (amt_q),
    .carry_in_i     (cin_q),
    .class_mask_i   (mask_q),
    .result_o       (dp_res)
  );

  assign out_valid_o   = out_valid_q;
  assign result_low_o  = res_q.lo;
  assign result_high_o = res_q.hi;
  assign flag_o        = res_q.flag;

  // accepted request lands in the input register
  `SAU_ASSERT_NEXT(a_take_lands, take_in, s1_valid_q, "accepted request lost")

  // a stage 1 item that advances becomes a valid result
  `SAU_ASSERT_NEXT(a_adv_valid, s1_valid_q && advance, out_valid_q, "result not produced")

  // a blocked stage 1 item stays put
  `SAU_ASSERT_NEXT(a_s1_hold, s1_valid_q && !advance,
                   s1_valid_q && $stable(op_q) && $stable(a_q) && $stable(b_q),
                   "blocked request changed")

  // only shifts produce a high half
  `SAU_ASSERT_NOW(a_hi_zero,
                  op_q != sau_pkg::OP_SHL && op_q != sau_pkg::OP_SHR,
                  dp_res.hi == 32'd0, "high half nonzero outside shifts")

endmodule

// ===== verif/sau_checker.sv =====
`timescale 1ns / 100ps
// sau_checker: watches both channels of shader_alu_helper_unit, predicts each result
// and compares it field by field with what the unit returns
// depends on: sau_pkg for the operation codes, result struct and float constants
module sau_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  operation_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic [5:0]  shift_amount_i,
  input  logic        carry_in_i,
  input  logic [9:0]  class_mask_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] result_low_i,
  input  logic [31:0] result_high_i,
  input  logic        flag_i,
  output int          pending_o,
  output int          fail_count_o
);

  sau_pkg::result_t expected_results[$];
  sau_pkg::result_t seen_result;
  sau_pkg::result_t oldest_result;
  int               mismatches = 0;

  // total order on float bits: negatives reversed below positives
  function automatic logic [31:0] float_order(logic [31:0] v);
    return v[31] ? ~v : {1'b1, v[30:0]};
  endfunction

  function automatic logic [31:0] float_min_max(logic [31:0] a, logic [31:0] b,
                                                logic want_max);
    logic a_nan;
    logic b_nan;
    a_nan = ((a & sau_pkg::F_EXP_MASK) == sau_pkg::F_EXP_MASK)
         && ((a & sau_pkg::F_MANT_MASK) != 32'd0);
    b_nan = ((b & sau_pkg::F_EXP_MASK) == sau_pkg::F_EXP_MASK)
         && ((b & sau_pkg::F_MANT_MASK) != 32'd0);
    if (a_nan && ((a & sau_pkg::F_QUIET) == 32'd0)) return a | sau_pkg::F_QUIET;
    if (b_nan && ((b & sau_pkg::F_QUIET) == 32'd0)) return b | sau_pkg::F_QUIET;
    if (a_nan) return b;
    if (b_nan) return a;
    // signed zeros: max prefers +0, min prefers -0
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return want_max ? (a & b) : (a | b);
    if (want_max) return (float_order(a) >= float_order(b)) ? a : b;
    return (float_order(a) < float_order(b)) ? a : b;
  endfunction

  function automatic sau_pkg::result_t predict_alu(logic [2:0] op, logic [31:0] a,
                                                   logic [31:0] b, logic [5:0] amt,
                                                   logic cin, logic [9:0] mask);
    sau_pkg::result_t res;
    logic [32:0]      sum;
    logic [7:0]       expo;
    logic [22:0]      mant;
    logic [15:0]      half;
    logic [23:0]      sig_shifted;
    logic [7:0]       half_expo;
    int unsigned      cls;
    res = '0;
    case (op)
      sau_pkg::OP_SHL: {res.hi, res.lo} = {b, a} << amt;
      sau_pkg::OP_SHR: {res.hi, res.lo} = {b, a} >> amt;
      sau_pkg::OP_ADDC: begin
        sum      = {1'b0, a} + {1'b0, b} + {32'd0, cin};
        res.lo   = sum[31:0];
        res.flag = sum[32];
      end
      sau_pkg::OP_F2H: begin
        expo = a[30:23];
        mant = a[22:0];
        half = {a[31], 15'd0};
        if (expo == sau_pkg::EXP_ALL_ONES) begin
          half = half | sau_pkg::H_INF;
          if (mant != 23'd0) half = half | {6'd0, mant[22:13]} | sau_pkg::H_QUIET;
        end else if (expo >= sau_pkg::EXP_SAT) begin
          half = half | sau_pkg::H_MAX_FINITE;
        end else if (expo >= sau_pkg::EXP_FLUSH && expo <= sau_pkg::EXP_SUB_TOP) begin
          sig_shifted = {1'b1, mant} >> (sau_pkg::SUB_BIAS - expo);
          half        = half | sig_shifted[15:0];
        end else if (expo > sau_pkg::EXP_SUB_TOP) begin
          half_expo = expo - sau_pkg::EXP_SUB_TOP;
          half      = half | {1'b0, half_expo[4:0], mant[22:13]};
        end
        res.lo = {16'd0, half};
      end
      sau_pkg::OP_CLASS: begin
        if ((a & sau_pkg::F_EXP_MASK) == sau_pkg::F_EXP_MASK) begin
          if ((a & sau_pkg::F_MANT_MASK) != 32'd0)
            cls = a[22] ? sau_pkg::CL_QNAN : sau_pkg::CL_SNAN;
          else cls = a[31] ? sau_pkg::CL_NINF : sau_pkg::CL_PINF;
        end else if ((a & sau_pkg::F_EXP_MASK) != 32'd0) begin
          cls = a[31] ? sau_pkg::CL_NNRM : sau_pkg::CL_PNRM;
        end else if ((a & sau_pkg::F_MANT_MASK) != 32'd0) begin
          cls = a[31] ? sau_pkg::CL_NDEN : sau_pkg::CL_PDEN;
        end else begin
          cls = a[31] ? sau_pkg::CL_NZER : sau_pkg::CL_PZER;
        end
        res.flag = mask[cls];
      end
      sau_pkg::OP_FMIN: res.lo = float_min_max(a, b, 1'b0);
      sau_pkg::OP_FMAX: res.lo = float_min_max(a, b, 1'b1);
      default: res = '0;
    endcase
    return res;
  endfunction

  task automatic report_field(input string field, input logic [31:0] want_v,
                              input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(predict_alu(operation_i, operand_a_i, operand_b_i,
                                               shift_amount_i, carry_in_i, class_mask_i));
      if (out_valid_i && !out_stall_i) begin
        seen_result.lo   = result_low_i;
        seen_result.hi   = result_high_i;
        seen_result.flag = flag_i;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual lo %h hi %h flag %b",
                   $time, result_low_i, result_high_i, flag_i);
          mismatches++;
        end else begin
          oldest_result = expected_results.pop_front();
          report_field("result_low", oldest_result.lo, seen_result.lo);
          report_field("result_high", oldest_result.hi, seen_result.hi);
          report_field("flag", {31'd0, oldest_result.flag}, {31'd0, seen_result.flag});
        end
      end
    end
    pending_o    <= expected_results.size();
    fail_count_o <= mismatches;
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: request stimulus, receiver stalls, watchdog and verdict for shader_alu_helper_unit
// depends on: sau_pkg, shader_alu_helper_unit and sau_checker
module tb_top;

  // operation code the unit leaves unused, it must answer with all zeros
  localparam logic [2:0]  OP_UNUSED    = 3'd7;
  localparam int unsigned RANDOM_COUNT = 1700;
  // stretches starting within this many requests of the end run with neither side idling
  localparam int unsigned CALM_TAIL    = 200;
  // cycles without any handshake before the run is declared hung
  localparam int unsigned STUCK_LIMIT  = 500;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  operation;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  logic [5:0]  shift_amount;
  logic        cin_bit;
  logic [9:0]  class_mask;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] result_low;
  logic [31:0] result_high;
  logic        flag;

  int          pending_count;
  int          fail_count;
  bit          idle_allowed = 1'b1;
  int unsigned stall_left   = 0;
  int unsigned stuck_cycles = 0;

  shader_alu_helper_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operation_i    (operation),
    .operand_a_i    (operand_a),
    .operand_b_i    (operand_b),
    .shift_amount_i (shift_amount),
    .carry_in_i     (cin_bit),
    .class_mask_i   (class_mask),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_low_o   (result_low),
    .result_high_o  (result_high),
    .flag_o         (flag)
  );

  sau_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .operation_i    (operation),
    .operand_a_i    (operand_a),
    .operand_b_i    (operand_b),
    .shift_amount_i (shift_amount),
    .carry_in_i     (cin_bit),
    .class_mask_i   (class_mask),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .result_low_i   (result_low),
    .result_high_i  (result_high),
    .flag_i         (flag),
    .pending_o      (pending_count),
    .fail_count_o   (fail_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // receiver side: stall bursts of random length, driven at the falling edge,
  // switched off entirely whenever idling is not allowed
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!idle_allowed) begin
        stall_left = 0;
      end else if (stall_left == 0 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9);
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // watchdog: counts cycles in which neither channel completes a handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("shader_alu_helper_unit verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // one request: optional idle burst first, then hold the payload until taken;
  // entered and left at a falling edge
  task automatic send_request(input logic [2:0] op, input logic [31:0] a,
                              input logic [31:0] b, input logic [5:0] amt,
                              input logic cin, input logic [9:0] mask);
    if (idle_allowed && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    operand_a    <= a;
    operand_b    <= b;
    shift_amount <= amt;
    cin_bit      <= cin;
    class_mask   <= mask;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // sender holds off until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // integer operand with a bias toward all zeros and all ones
  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // float operand weighted toward zeros, denormals, infinities, nans and the
  // exponents around the half conversion boundaries
  function automatic logic [31:0] random_float();
    logic        sign;
    logic [7:0]  expo;
    logic [22:0] mant;
    sign = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0:       expo = 8'h00;
      1:       expo = 8'hff;
      2, 3:    expo = 8'($urandom_range(100, 146));
      default: expo = 8'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       mant = 23'h000000;
      1:       mant = 23'h400000 | (23'($urandom) & 23'h3fffff);
      2:       mant = 23'($urandom) & 23'h3fffff;
      3:       mant = 23'h7fffff;
      default: mant = 23'($urandom);
    endcase
    return {sign, expo, mant};
  endfunction

  initial begin
    logic [2:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    operation    = sau_pkg::OP_SHL;
    operand_a    = 32'd0;
    operand_b    = 32'd0;
    shift_amount = 6'd0;
    cin_bit      = 1'b0;
    class_mask   = 10'd0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    // shifts: no shift, the full 63, the half-word boundary, single bit
    send_request(sau_pkg::OP_SHL, 32'h8000_0001, 32'h0000_0000, 6'd0, 1'b0, 10'd0);
    send_request(sau_pkg::OP_SHL, 32'hffff_ffff, 32'hffff_ffff, 6'd63, 1'b0, 10'd0);
    send_request(sau_pkg::OP_SHL, 32'h1234_5678, 32'h9abc_def0, 6'd32, 1'b0, 10'd0);
    send_request(sau_pkg::OP_SHR, 32'h8000_0001, 32'hffff_ffff, 6'd1, 1'b0, 10'd0);
    send_request(sau_pkg::OP_SHR, 32'h1234_5678, 32'h8000_0000, 6'd63, 1'b0, 10'd0);
    send_request(sau_pkg::OP_SHR, 32'h1234_5678, 32'h9abc_def0, 6'd32, 1'b0, 10'd0);
    // add: carry produced only by the carry in, and by the operands together with it
    send_request(sau_pkg::OP_ADDC, 32'hffff_ffff, 32'h0000_0000, 6'd0, 1'b1, 10'd0);
    send_request(sau_pkg::OP_ADDC, 32'hffff_ffff, 32'hffff_ffff, 6'd0, 1'b1, 10'd0);
    // half conversion: infinity, signalling nan with payload, largest value
    // below saturation, negative saturation, flush, the subnormal range ends,
    // smallest normal half
    send_request(sau_pkg::OP_F2H, 32'h7f80_0000, 32'd0, 6'd0, 1'b0, 10'd0);
    send_request(sau_pkg::OP_F2H, 32'hff81_2345, 32'd0, 6'd0, 1'b0, 10'd0);
    send_request(sau_pkg::OP_F2H, 32'h477f_ffff, 32'd0, 6'd0, 1'b0, 10'd0);
    send_request(sau_pkg::OP_F2H, 32'hc780_0000, 32'd0, 6'd0, 1'b0, 10'd0);
    send_request(sau_pkg::OP_F2H, 32'h3300_0000, 32'd0, 6'd0, 1'b0, 10'd0);
    send_request(sau_pkg::OP_F2H, 32'hb380_0000, 32'd0, 6'd0, 1'b0, 10'd0);
    send_request(sau_pkg::OP_F2H, 32'h387f_ffff, 32'd0, 6'd0, 1'b0, 10'd0);
    send_request(sau_pkg::OP_F2H, 32'h3880_0000, 32'd0, 6'd0, 1'b0, 10'd0);
    // class test: hit on its own bit, miss with every other bit set
    send_request(sau_pkg::OP_CLASS, 32'hff80_0001, 32'd0, 6'd0, 1'b0,
                 10'b1 << sau_pkg::CL_SNAN);
    send_request(sau_pkg::OP_CLASS, 32'h7fc0_0000, 32'd0, 6'd0, 1'b0,
                 ~(10'b1 << sau_pkg::CL_QNAN));
    send_request(sau_pkg::OP_CLASS, 32'h0000_0001, 32'd0, 6'd0, 1'b0,
                 10'b1 << sau_pkg::CL_PDEN);
    // min and max: nan priority, signed zeros, equal values, ordinary order
    send_request(sau_pkg::OP_FMIN, 32'h7f80_0001, 32'h7fc0_0000, 6'd0, 1'b0, 10'd0);
    send_request(sau_pkg::OP_FMAX, 32'h7fc0_0000, 32'h3f80_0000, 6'd0, 1'b0, 10'd0);
    send_request(sau_pkg::OP_FMIN, 32'h3f80_0000, 32'hff80_0001, 6'd0, 1'b0, 10'd0);
    send_request(sau_pkg::OP_FMIN, 32'h0000_0000, 32'h8000_0000, 6'd0, 1'b0, 10'd0);
    send_request(sau_pkg::OP_FMAX, 32'h8000_0000, 32'h0000_0000, 6'd0, 1'b0, 10'd0);
    send_request(sau_pkg::OP_FMAX, 32'h3f80_0000, 32'h3f80_0000, 6'd0, 1'b0, 10'd0);
    send_request(sau_pkg::OP_FMIN, 32'hbf80_0000, 32'h3f80_0000, 6'd0, 1'b0, 10'd0);
    send_request(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 6'd63, 1'b1, 10'h3ff);
    drain_results();

    // random part: idling switched per stretch of 64 requests, none at the end
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      if (i % 64 == 0)
        idle_allowed = (i < RANDOM_COUNT - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      if (i == RANDOM_COUNT / 2) drain_results();
      op = 3'($urandom_range(0, 7));
      if (op >= sau_pkg::OP_F2H) begin
        a = random_float();
        b = random_float();
      end else begin
        a = random_word();
        b = random_word();
      end
      // equal or sign-flipped operands for min and max
      if ((op == sau_pkg::OP_FMIN || op == sau_pkg::OP_FMAX) && $urandom_range(0, 7) == 0)
        b = a ^ ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h0000_0000);
      send_request(op, a, b, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                   10'($urandom_range(0, 1023)));
    end

    drain_results();
    // idle time to catch a stray result arriving after the drain
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("shader_alu_helper_unit verification clean");
    end else begin
      $display("shader_alu_helper_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== shader_alu_helper_unit.f =====
+incdir+rtl
rtl/sau_pkg.sv
rtl/sau_datapath.sv
rtl/shader_alu_helper_unit.sv
verif/sau_checker.sv
verif/tb_top.sv
